// File: rtl/sfd_pkg.sv
// Shared types, codes and sizes of the sync word frame deframer.
package sfd_pkg;

  // Frame layout and sizing.
  localparam int MAX_FRAME = 2048;
  localparam int HDR_LEN   = 8;
  localparam int BEAT_W    = $clog2(HDR_LEN);

  // Largest payload length that still fits, and the swallow count of an oversized frame.
  localparam logic [16:0] LEN_LIMIT   = 17'(MAX_FRAME - HDR_LEN);
  localparam int          DISC_W      = $clog2(MAX_FRAME - HDR_LEN + 2);
  localparam logic [DISC_W-1:0] DISC_START = DISC_W'(MAX_FRAME - HDR_LEN + 1);

  // Command queue between the parser and the beat expander.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_TYPE = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [31:0] SIGNATURE_RST   = 32'h0BAD_F00D;
  localparam logic [15:0] STATUS_TYPE_RST = 16'h0004;

  // Result kinds.
  localparam logic [1:0] KIND_FWD       = 2'd0;
  localparam logic [1:0] KIND_STATUS_OK = 2'd1;
  localparam logic [1:0] KIND_SHORT     = 2'd2;

  // One queued command: a single result beat or a whole header burst.
  typedef struct packed {
    logic            burst;
    logic [1:0]      kind;
    logic            frame_end;
    logic [7:0][7:0] bytes;
    logic [7:0]      root;
    logic [7:0]      version;
  } cmd_t;

endpackage

// File: rtl/sfd_front.sv
// Parser front end: header hunting, frame classification and command generation.
module sfd_front import sfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            rx_byte,
  input  logic                  q_full,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  q_wr,
  output cmd_t                  q_cmd
);

  localparam logic [1:0] MODE_HUNT    = 2'd0;
  localparam logic [1:0] MODE_FWD     = 2'd1;
  localparam logic [1:0] MODE_STATUS  = 2'd2;
  localparam logic [1:0] MODE_DISCARD = 2'd3;

  logic [31:0]       signature;
  logic [15:0]       status_type;
  logic [7:0][7:0]   window, window_next;
  logic [2:0]        fill, fill_next;
  logic [1:0]        mode, mode_next;
  logic [15:0]       bytes_left, bytes_left_next;
  logic [1:0]        pidx, pidx_next;
  logic [DISC_W-1:0] discard_left, discard_left_next;
  logic [7:0]        pending_root, pending_root_next;
  logic [7:0]        pending_version, pending_version_next;
  logic [7:0]        held_root, held_root_next;
  logic [7:0]        held_version, held_version_next;

  logic              accept;
  logic [7:0][7:0]   win_new;
  logic [31:0]       hdr_sig;
  logic [15:0]       hdr_type;
  logic [15:0]       hdr_len;
  logic              last;

  assign accept = push & ~q_full;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      signature   <= SIGNATURE_RST;
      status_type <= STATUS_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIGNATURE:   signature   <= cfg_wdata;
        CFG_STATUS_TYPE: status_type <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // The header window with the new byte dropped in at the fill position.
  always_comb begin
    win_new       = window;
    win_new[fill] = rx_byte;
  end

  assign hdr_sig  = {win_new[3], win_new[2], win_new[1], win_new[0]};
  assign hdr_type = {win_new[5], win_new[4]};
  assign hdr_len  = {win_new[7], win_new[6]};
  assign last     = (bytes_left <= 16'd1);

  // Next state of the parser and the command that the byte produces.
  always_comb begin
    window_next          = window;
    fill_next            = fill;
    mode_next            = mode;
    bytes_left_next      = bytes_left;
    pidx_next            = pidx;
    discard_left_next    = discard_left;
    pending_root_next    = pending_root;
    pending_version_next = pending_version;
    held_root_next       = held_root;
    held_version_next    = held_version;
    q_wr                 = 1'b0;
    q_cmd                = '0;

    unique case (mode)
      MODE_FWD: begin
        bytes_left_next = last ? 16'd0 : bytes_left - 16'd1;
        if (last) begin
          mode_next = MODE_HUNT;
        end
        q_wr            = 1'b1;
        q_cmd.kind      = KIND_FWD;
        q_cmd.bytes[0]  = rx_byte;
        q_cmd.frame_end = last;
      end
      MODE_STATUS: begin
        if (pidx == 2'd0) begin
          pending_root_next = rx_byte;
        end
        if (pidx == 2'd1) begin
          pending_version_next = rx_byte;
        end
        pidx_next       = (pidx == 2'd2) ? 2'd2 : pidx + 2'd1;
        bytes_left_next = last ? 16'd0 : bytes_left - 16'd1;
        if (last) begin
          mode_next       = MODE_HUNT;
          q_wr            = 1'b1;
          q_cmd.frame_end = 1'b1;
          if (pidx_next == 2'd2) begin
            held_root_next    = pending_root_next;
            held_version_next = pending_version_next;
            q_cmd.kind        = KIND_STATUS_OK;
          end else begin
            q_cmd.kind = KIND_SHORT;
          end
        end
      end
      MODE_DISCARD: begin
        discard_left_next = (discard_left != '0) ? discard_left - DISC_W'(1) : discard_left;
        if (discard_left_next == '0) begin
          mode_next = MODE_HUNT;
          fill_next = 3'd0;
        end
      end
      MODE_HUNT: begin
        if (fill != 3'd7) begin
          window_next = win_new;
          fill_next   = fill + 3'd1;
        end else if (hdr_sig != signature) begin
          // Slide the window by one byte and keep hunting.
          window_next = {8'h00, win_new[7:1]};
          fill_next   = 3'd7;
        end else begin
          window_next = win_new;
          fill_next   = 3'd0;
          if ({1'b0, hdr_len} > LEN_LIMIT) begin
            mode_next         = MODE_DISCARD;
            discard_left_next = DISC_START;
          end else if (hdr_type == status_type) begin
            if (hdr_len == 16'd0) begin
              q_wr            = 1'b1;
              q_cmd.kind      = KIND_SHORT;
              q_cmd.frame_end = 1'b1;
            end else begin
              mode_next       = MODE_STATUS;
              bytes_left_next = hdr_len;
              pidx_next       = 2'd0;
            end
          end else begin
            q_wr            = 1'b1;
            q_cmd.burst     = 1'b1;
            q_cmd.kind      = KIND_FWD;
            q_cmd.bytes     = win_new;
            q_cmd.frame_end = (hdr_len == 16'd0);
            if (hdr_len != 16'd0) begin
              mode_next       = MODE_FWD;
              bytes_left_next = hdr_len;
            end
          end
        end
      end
      default: ;
    endcase

    q_cmd.root    = held_root_next;
    q_cmd.version = held_version_next;
    q_wr          = q_wr & accept;
  end

  // Parser state advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      window          <= '0;
      fill            <= 3'd0;
      mode            <= MODE_HUNT;
      bytes_left      <= 16'd0;
      pidx            <= 2'd0;
      discard_left    <= '0;
      pending_root    <= 8'd0;
      pending_version <= 8'd0;
      held_root       <= 8'd0;
      held_version    <= 8'd0;
    end else if (accept) begin
      window          <= window_next;
      fill            <= fill_next;
      mode            <= mode_next;
      bytes_left      <= bytes_left_next;
      pidx            <= pidx_next;
      discard_left    <= discard_left_next;
      pending_root    <= pending_root_next;
      pending_version <= pending_version_next;
      held_root       <= held_root_next;
      held_version    <= held_version_next;
    end
  end

`ifndef SYNTHESIS
  // A command is never written into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_wr |-> !q_full)
    else $error("command written into a full queue");

  // An oversized frame being swallowed produces no commands.
  assert property (@(posedge clk) disable iff (rst) (mode == MODE_DISCARD) |-> !q_wr)
    else $error("command produced while discarding");
`endif

endmodule

// File: rtl/sfd_cmd_q.sv
// Short command queue between the parser and the beat expander.
module sfd_cmd_q import sfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Command storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the queue depth.
  assert property (@(posedge clk) disable iff (rst) count <= (QPTR_W+1)'(QDEPTH))
    else $error("command queue overflow");

  // The back end never reads an empty queue.
  assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("command queue read while empty");
`endif

endmodule

// File: rtl/sfd_back.sv
// Beat expander: turns queued commands into result beats.
module sfd_back import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  input  logic       pop,
  output logic       q_rd,
  output logic [1:0] result_kind,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic [7:0] root_value,
  output logic [7:0] version
);

  logic [BEAT_W-1:0] beat;
  logic              last_beat;
  logic              take;

  assign last_beat = !head.burst || (beat == BEAT_W'(HDR_LEN - 1));
  assign take      = pop & ~q_empty;
  assign q_rd      = take & last_beat;

  // Result fields of the current beat.
  assign result_kind = head.kind;
  assign out_byte    = head.burst ? head.bytes[beat] : head.bytes[0];
  assign frame_end   = head.frame_end & last_beat;
  assign root_value  = head.root;
  assign version     = head.version;

  // Beat position within a header burst.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else if (take) begin
      beat <= last_beat ? '0 : beat + BEAT_W'(1);
    end
  end

`ifndef SYNTHESIS
  // A burst in progress always has its command at the queue head.
  assert property (@(posedge clk) disable iff (rst) (beat != '0) |-> (!q_empty && head.burst))
    else $error("burst position without a burst command");
`endif

endmodule

// File: rtl/sync_word_frame_deframer_top.sv
// Throughput: one received beat per cycle while full is low; a header burst drains at
// one result beat per cycle while pop is high from an eight-entry command queue, and
// full rises only while that queue is full. Accepted beats' commands wait there.
// Reset: synchronous active-high rst clears the parser, the queue and the latched status,
// and restores frame_signature to 0x0BADF00D and status_frame_type to 4.
module sync_word_frame_deframer_top import sfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            rx_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            result_kind,
  output logic [7:0]            out_byte,
  output logic                  frame_end,
  output logic [7:0]            root_value,
  output logic [7:0]            version,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  assign full  = q_full;
  assign empty = q_empty;

  // Front end: parse received beats into commands.
  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_wr      (q_wr),
    .q_cmd     (q_cmd)
  );

  // Decoupling queue.
  sfd_cmd_q u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_cmd (q_cmd),
    .rd     (q_rd),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back end: expand commands into result beats.
  sfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (pop),
    .q_rd        (q_rd),
    .result_kind (result_kind),
    .out_byte    (out_byte),
    .frame_end   (frame_end),
    .root_value  (root_value),
    .version     (version)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the sync word frame deframer with a byte-level predictor.
`timescale 1ns / 1ps

module testbench import sfd_pkg::*; ();

  // Index values that decode to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  // Cycles with no accepted beat on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [1:0] {MODE_HUNT, MODE_FWD, MODE_STATUS, MODE_DISCARD} parse_mode_t;

  // One result beat as the block should deliver it.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       tail;
    logic [7:0] root;
    logic [7:0] ver;
  } deframed_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            rx_byte = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [1:0]            result_kind;
  logic [7:0]            out_byte;
  logic                  frame_end;
  logic [7:0]            root_value;
  logic [7:0]            version;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Bytes waiting to be offered, and result beats predicted but not yet seen.
  logic [7:0]     rx_stream [$];
  deframed_beat_t beats_due [$];

  int send_idle_pct = 12;
  int recv_idle_pct = 57;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Predictor copy of the configuration and the parser state.
  logic [31:0]  sig_reg;
  logic [15:0]  stype_reg;
  logic [7:0]   win [HDR_LEN];
  int           fill;
  parse_mode_t  mode;
  logic [15:0]  left;
  logic [15:0]  pidx;
  int           disc_cnt;
  logic [7:0]   pend_root, pend_ver, held_root, held_ver;

  sync_word_frame_deframer_top u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .empty      (empty),
    .pop        (pop),
    .result_kind(result_kind),
    .out_byte   (out_byte),
    .frame_end  (frame_end),
    .root_value (root_value),
    .version    (version),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Queue one expected beat, tagged with the status values latched so far.
  function automatic void add_beat(input logic [1:0] kind, input logic [7:0] data,
                                   input logic is_end);
    deframed_beat_t beat;
    beat.kind = kind;
    beat.data = data;
    beat.tail = is_end;
    beat.root = held_root;
    beat.ver  = held_ver;
    beats_due.push_back(beat);
  endfunction

  // Advance the parser by one received byte and queue the beats it causes.
  task automatic deframe_byte(input logic [7:0] b);
    logic        is_end;
    logic [31:0] sync;
    logic [15:0] ftype, flen;
    int          i;
    case (mode)
      MODE_FWD: begin
        is_end = (left <= 1);
        left = is_end ? 16'd0 : left - 16'd1;
        if (is_end) mode = MODE_HUNT;
        add_beat(KIND_FWD, b, is_end);
      end
      MODE_STATUS: begin
        if (pidx == 0) pend_root = b;
        else if (pidx == 1) pend_ver = b;
        pidx = pidx + 16'd1;
        is_end = (left <= 1);
        left = is_end ? 16'd0 : left - 16'd1;
        if (is_end) begin
          mode = MODE_HUNT;
          if (pidx >= 2) begin
            held_root = pend_root;
            held_ver  = pend_ver;
            add_beat(KIND_STATUS_OK, 8'h00, 1'b1);
          end else begin
            add_beat(KIND_SHORT, 8'h00, 1'b1);
          end
        end
      end
      MODE_DISCARD: begin
        if (disc_cnt > 0) disc_cnt--;
        if (disc_cnt == 0) begin
          mode = MODE_HUNT;
          fill = 0;
        end
      end
      default: begin
        if (fill > HDR_LEN - 1) fill = HDR_LEN - 1;
        win[fill] = b;
        fill++;
        if (fill == HDR_LEN) begin
          sync = {win[3], win[2], win[1], win[0]};
          if (sync != sig_reg) begin
            // No sync word at the front: slide the window by one byte.
            for (i = 0; i < HDR_LEN - 1; i++) win[i] = win[i + 1];
            win[HDR_LEN - 1] = 8'h00;
            fill = HDR_LEN - 1;
          end else begin
            ftype = {win[5], win[4]};
            flen  = {win[7], win[6]};
            fill  = 0;
            if (HDR_LEN + int'(flen) > MAX_FRAME) begin
              mode = MODE_DISCARD;
              disc_cnt = MAX_FRAME - HDR_LEN + 1;
            end else if (ftype == stype_reg) begin
              if (flen == 0) begin
                add_beat(KIND_SHORT, 8'h00, 1'b1);
              end else begin
                mode = MODE_STATUS;
                left = flen;
                pidx = '0;
              end
            end else begin
              for (i = 0; i < HDR_LEN; i++)
                add_beat(KIND_FWD, win[i], (flen == 0) && (i == HDR_LEN - 1));
              if (flen != 0) begin
                mode = MODE_FWD;
                left = flen;
              end
            end
          end
        end
      end
    endcase
  endtask

  // Append one frame to the stream; an oversized frame gets only its header, and the
  // parser then swallows the next MAX_FRAME - HDR_LEN + 1 bytes that follow it.
  // Returns the number of bytes appended.
  function automatic int add_frame(input logic [31:0] sync, input logic [15:0] ftype,
                                   input int plen);
    int          body;
    int          i;
    logic [15:0] len16;
    len16 = 16'(plen);
    body = (HDR_LEN + plen > MAX_FRAME) ? 0 : plen;
    for (i = 0; i < 4; i++) rx_stream.push_back(sync[8*i +: 8]);
    rx_stream.push_back(ftype[7:0]);
    rx_stream.push_back(ftype[15:8]);
    rx_stream.push_back(len16[7:0]);
    rx_stream.push_back(len16[15:8]);
    repeat (body) rx_stream.push_back(8'($urandom));
    return HDR_LEN + body;
  endfunction

  function automatic int add_noise(input int n);
    repeat (n) rx_stream.push_back(8'($urandom));
    return n;
  endfunction

  // Mostly well-formed frames with random content, plus corrupted sync words and line noise.
  task automatic run_random(input int budget, input logic [31:0] sig, input logic [15:0] stype);
    int          planned;
    int          r;
    int          plen;
    logic [15:0] ftype;
    planned = 0;
    while (planned < budget) begin
      r = $urandom_range(99);
      ftype = ($urandom_range(1) != 0) ? stype : 16'($urandom);
      if (r < 20) plen = $urandom_range(2);
      else if (r < 28) plen = $urandom_range(40, 17);
      else plen = $urandom_range(16, 3);
      if (r >= 90) planned += add_noise($urandom_range(6, 1));
      else if (r >= 80) planned += add_frame(sig ^ (32'd1 << $urandom_range(31)), ftype, plen);
      else planned += add_frame(sig, ftype, plen);
    end
  endtask

  // Wait until every byte is taken and every predicted beat has come out.
  task automatic wait_idle();
    do @(posedge clk);
    while (rx_stream.size() != 0 || push || beats_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Byte driver: offers the next byte and applies register writes to the predictor.
  always @(posedge clk) begin : drive_rx
    logic holding;
    if (rst) begin
      sig_reg   = SIGNATURE_RST;
      stype_reg = STATUS_TYPE_RST;
      foreach (win[i]) win[i] = 8'h00;
      fill      = 0;
      mode      = MODE_HUNT;
      left      = '0;
      pidx      = '0;
      disc_cnt  = 0;
      pend_root = '0;
      pend_ver  = '0;
      held_root = '0;
      held_ver  = '0;
      beats_due.delete();
      push <= 1'b0;
    end else begin
      holding = push;
      if (push && !full) begin
        deframe_byte(rx_byte);
        holding = 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIGNATURE:   sig_reg = cfg_wdata;
          CFG_STATUS_TYPE: stype_reg = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (!holding) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_byte <= rx_stream.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each popped beat with the oldest prediction.
  always @(posedge clk) begin : watch_results
    deframed_beat_t due;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (beats_due.size() == 0) begin
          $display("%0t: result beat mismatch, expected none, actual kind %0h byte %0h",
                   $time, result_kind, out_byte);
          mismatch_count++;
        end else begin
          due = beats_due.pop_front();
          check_field("result_kind", 8'(due.kind), 8'(result_kind));
          check_field("out_byte", due.data, out_byte);
          check_field("frame_end", 8'(due.tail), 8'(frame_end));
          check_field("root_value", due.root, root_value);
          check_field("version", due.ver, version);
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hang detector: too long without a beat moving on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("sync_word_frame_deframer_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_phases
    logic [31:0] rnd_sig;
    logic [15:0] rnd_type;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset configuration.
    void'(add_frame(SIGNATURE_RST, 16'h0000, 0));
    void'(add_frame(SIGNATURE_RST, STATUS_TYPE_RST, 0));
    void'(add_frame(SIGNATURE_RST, STATUS_TYPE_RST, 1));
    void'(add_frame(SIGNATURE_RST, STATUS_TYPE_RST, 2));
    void'(add_frame(SIGNATURE_RST, 16'hFFFF, 3));
    void'(add_noise(3));
    void'(add_frame(SIGNATURE_RST, STATUS_TYPE_RST, 5));
    void'(add_frame(SIGNATURE_RST, 16'h0001, 1));
    void'(add_frame(SIGNATURE_RST, 16'h8000, 2));
    wait_idle();

    // Random configuration; the spare indexes must not disturb it.
    rnd_sig  = $urandom;
    rnd_type = 16'($urandom);
    write_reg(CFG_SIGNATURE, rnd_sig);
    write_reg(CFG_STATUS_TYPE, {16'hFFFF, rnd_type});
    write_reg(CFG_SPARE_2, 32'h0000_0000);
    write_reg(CFG_SPARE_3, ~rnd_sig);
    @(posedge clk);
    cfg_we <= 1'b0;
    run_random(45, rnd_sig, rnd_type);
    wait_idle();

    // All-ones configuration with the idle rates swapped.
    send_idle_pct = 57;
    recv_idle_pct = 12;
    write_reg(CFG_SIGNATURE, 32'hFFFF_FFFF);
    write_reg(CFG_STATUS_TYPE, 32'h0000_FFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    run_random(40, 32'hFFFF_FFFF, 16'hFFFF);
    wait_idle();

    // All-zero configuration at full rate on both sides, ending in an oversized header
    // whose trailing bytes are swallowed.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_SIGNATURE, 32'h0000_0000);
    write_reg(CFG_STATUS_TYPE, 32'h0000_0000);
    @(posedge clk);
    cfg_we <= 1'b0;
    run_random(40, 32'h0000_0000, 16'h0000);
    void'(add_frame(32'h0000_0000, 16'h0001, MAX_FRAME - HDR_LEN + 1));
    void'(add_noise(3));
    wait_idle();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sync_word_frame_deframer_top test passed");
    end else begin
      $display("sync_word_frame_deframer_top test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_cmd_q.sv
rtl/sfd_back.sv
rtl/sync_word_frame_deframer_top.sv
tb/testbench.sv
